FILE: hdl/stt_pkg.sv
// Tokenizer package: token kinds, error codes, character constants, record type,
// operator and keyword lookup functions.
// No dependencies.
package stt_pkg;

   localparam logic [6:0] K_DOT          = 7'd37;
   localparam logic [6:0] K_SLASH        = 7'd43;
   localparam logic [6:0] K_SLASH_ASSIGN = 7'd44;
   localparam logic [6:0] K_EOL          = 7'd45;
   localparam logic [6:0] K_END          = 7'd46;
   localparam logic [6:0] K_INT          = 7'd47;
   localparam logic [6:0] K_FLOAT        = 7'd48;
   localparam logic [6:0] K_IDENT        = 7'd49;
   localparam logic [6:0] K_CHAR         = 7'd50;
   localparam logic [6:0] K_STR          = 7'd51;
   localparam logic [6:0] K_LOAD         = 7'd52;
   localparam logic [6:0] K_ERROR        = 7'd53;
   localparam logic [6:0] K_KW0          = 7'd54;

   localparam logic [2:0] E_NONE      = 3'd0;
   localparam logic [2:0] E_BAD_CHAR  = 3'd1;
   localparam logic [2:0] E_BAD_DIGIT = 3'd2;
   localparam logic [2:0] E_DIRECT    = 3'd3;
   localparam logic [2:0] E_NUM_ESC   = 3'd4;
   localparam logic [2:0] E_OPEN_STR  = 3'd5;
   localparam logic [2:0] E_OPEN_CHAR = 3'd6;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_LOW_B  = 8'h62;

   localparam logic [23:0] LINE_TOP = 24'hFFFFFF;

   typedef struct packed {
      logic [6:0]  kind;
      logic [2:0]  err;
      logic [23:0] start_pos;
      logic [23:0] end_pos;
      logic [23:0] line;
      logic [63:0] int_val;
      logic [63:0] frac_val;
      logic [5:0]  frac_cnt;
      logic [63:0] exp_val;
   } rec_type;

   // keywords right-justified, first character in the top occupied byte
   localparam logic [63:0] KW_TEXT [33] = '{
      64'("true"), 64'("false"), 64'("decl"), 64'("let"), 64'("if"), 64'("else"),
      64'("for"), 64'("while"), 64'("loop"), 64'("continue"), 64'("break"),
      64'("return"), 64'("in"), 64'("as"), 64'("struct"), 64'("enum"), 64'("union"),
      64'("nothing"), 64'("char"), 64'("bool"), 64'("ubyte"), 64'("ibyte"),
      64'("uword"), 64'("iword"), 64'("ulong"), 64'("ilong"), 64'("uquad"),
      64'("iquad"), 64'("flong"), 64'("fquad"), 64'("rawptr"), 64'("string"),
      64'("cstring")};
   localparam logic [3:0] KW_LEN [33] = '{
      4'd4, 4'd5, 4'd4, 4'd3, 4'd2, 4'd4, 4'd3, 4'd5, 4'd4, 4'd8, 4'd5, 4'd6, 4'd2,
      4'd2, 4'd6, 4'd4, 4'd5, 4'd7, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
      4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7};

   // w holds character i in byte i; n is 0 when the word overran the buffer
   function automatic logic [6:0] word_kind(input logic [63:0] w, input logic [3:0] n);
      logic [6:0] k;
      logic       hit;
      k = K_IDENT;
      for (int i = 32; i >= 0; i--) begin
         hit = (n == KW_LEN[i]);
         for (int j = 0; j < 8; j++) begin
            if (j < int'(n)) begin
               if (w[8*j +: 8] != KW_TEXT[i][8*(int'(n)-1-j) +: 8]) hit = 1'b0;
            end
         end
         if (hit) k = K_KW0 + 7'(i);
      end
      return k;
   endfunction

   function automatic logic is_load(input logic [63:0] w, input logic [3:0] n);
      return (n == 4'd4) && (w[31:0] == 32'("daol"));
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= "0" && c <= "9") v = 4'(c - 8'h30);
      else if (c >= "a" && c <= "f") v = 4'(c - 8'h57);
      else if (c >= "A" && c <= "F") v = 4'(c - 8'h37);
      return v;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return is_letter(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic logic [63:0] mul10_add(input logic [63:0] x, input logic [3:0] d);
      return (x << 3) + (x << 1) + 64'(d);
   endfunction

   function automatic logic [7:0] escape_value(input logic [7:0] c);
      logic [7:0] v;
      case (c)
         "r":     v = 8'd13;
         "n":     v = 8'd10;
         "t":     v = 8'd9;
         "v":     v = 8'd11;
         default: v = c;
      endcase
      return v;
   endfunction

   // {found, takes a second character, kind of the single-character form}
   function automatic logic [8:0] op_bare(input logic [7:0] c);
      logic [8:0] r;
      unique case (c)
         "[":     r = {2'b10, 7'd0};
         "]":     r = {2'b10, 7'd1};
         "{":     r = {2'b10, 7'd2};
         "}":     r = {2'b10, 7'd3};
         "(":     r = {2'b10, 7'd4};
         ")":     r = {2'b10, 7'd5};
         "!":     r = {2'b11, 7'd6};
         "$":     r = {2'b10, 7'd8};
         "%":     r = {2'b11, 7'd9};
         "^":     r = {2'b11, 7'd11};
         "&":     r = {2'b11, 7'd14};
         "*":     r = {2'b11, 7'd17};
         "-":     r = {2'b11, 7'd19};
         "+":     r = {2'b11, 7'd23};
         "=":     r = {2'b11, 7'd26};
         "|":     r = {2'b11, 7'd29};
         ";":     r = {2'b10, 7'd32};
         ":":     r = {2'b11, 7'd33};
         ",":     r = {2'b10, 7'd36};
         ".":     r = {2'b11, 7'd37};
         "<":     r = {2'b11, 7'd39};
         ">":     r = {2'b11, 7'd41};
         default: r = '0;
      endcase
      return r;
   endfunction

   // {matched, kind of the two-character form}
   function automatic logic [7:0] op_pair(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      unique case ({a, b})
         {"!", "="}: r = {1'b1, 7'd7};
         {"%", "="}: r = {1'b1, 7'd10};
         {"^", "^"}: r = {1'b1, 7'd12};
         {"^", "="}: r = {1'b1, 7'd13};
         {"&", "&"}: r = {1'b1, 7'd15};
         {"&", "="}: r = {1'b1, 7'd16};
         {"*", "="}: r = {1'b1, 7'd18};
         {"-", "-"}: r = {1'b1, 7'd20};
         {"-", "="}: r = {1'b1, 7'd21};
         {"-", ">"}: r = {1'b1, 7'd22};
         {"+", "+"}: r = {1'b1, 7'd24};
         {"+", "="}: r = {1'b1, 7'd25};
         {"=", "="}: r = {1'b1, 7'd27};
         {"=", ">"}: r = {1'b1, 7'd28};
         {"|", "|"}: r = {1'b1, 7'd30};
         {"|", "="}: r = {1'b1, 7'd31};
         {":", ":"}: r = {1'b1, 7'd34};
         {":", "="}: r = {1'b1, 7'd35};
         {".", "."}: r = {1'b1, 7'd38};
         {"<", "="}: r = {1'b1, 7'd40};
         {">", "="}: r = {1'b1, 7'd42};
         default:    r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/stt_if.sv
// Tokenizer channel interfaces: source byte words in, token record words out.
// Depends on nothing.
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_text;
   modport source (output valid, byte_in, end_of_text, input ready);
   modport sink (input valid, byte_in, end_of_text, output ready);
endinterface

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  token_kind;
   logic [2:0]  error_code;
   logic [23:0] start_pos;
   logic [23:0] end_pos;
   logic [23:0] line_no;
   logic [63:0] int_value;
   logic [63:0] frac_value;
   logic [5:0]  frac_digits;
   logic [63:0] exp_value;
   logic        last_token;
   modport source (output valid, token_kind, error_code, start_pos, end_pos, line_no,
                   int_value, frac_value, frac_digits, exp_value, last_token,
                   input ready);
   modport sink (input valid, token_kind, error_code, start_pos, end_pos, line_no,
                 int_value, frac_value, frac_digits, exp_value, last_token,
                 output ready);
endinterface

FILE: hdl/source_text_tokenizer.sv
// Streaming tokenizer top level: scanner state, per-byte token logic, record buffer.
// Depends on stt_pkg and the stt_req_if / stt_rsp_if interfaces.
//
// Usage:
//   req_chan carries one source byte per word, or an end_of_text word which
//   flushes the pending token, emits the end token and returns the scanner to
//   its reset state for the next text.
//   rsp_chan carries token records, one per word; last_token marks the final
//   record caused by one input word.
//   An accepted byte is scanned in the cycle it is taken and its records (zero
//   to three) appear on rsp_chan in the next cycle, one per cycle while the
//   receiver is ready. Throughput is one byte per cycle while each byte yields
//   at most one record and the receiver is ready; a byte yielding more records
//   holds req_chan while the three-entry record buffer drains.
//   When the receiver stalls, the buffer holds its records and req_chan takes
//   one more word only if the last waiting record leaves in the same cycle.
//   Reset (synchronous, active high) empties the buffer, sets line to 1 and
//   position to 0.
module source_text_tokenizer
   import stt_pkg::*;
#(
   parameter int POSITION_BITS     = 24,
   parameter int KEYWORD_MAX_CHARS = 8
) (
   input logic        clock,
   input logic        reset,
   stt_req_if.sink    req_chan,
   stt_rsp_if.source  rsp_chan
);

   localparam int PB  = POSITION_BITS;
   localparam int WLW = $clog2(KEYWORD_MAX_CHARS + 2);
   localparam int IW  = $clog2(KEYWORD_MAX_CHARS);
   localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_OP         = 4'd1;
   localparam logic [3:0] S_SLASH      = 4'd2;
   localparam logic [3:0] S_LINE_CMT   = 4'd3;
   localparam logic [3:0] S_BLOCK_CMT  = 4'd4;
   localparam logic [3:0] S_INT        = 4'd5;
   localparam logic [3:0] S_NUM_DOT    = 4'd6;
   localparam logic [3:0] S_FRAC       = 4'd7;
   localparam logic [3:0] S_EXP        = 4'd8;
   localparam logic [3:0] S_IDENT      = 4'd9;
   localparam logic [3:0] S_DIRECT     = 4'd10;
   localparam logic [3:0] S_CHAR_OPEN  = 4'd11;
   localparam logic [3:0] S_CHAR_ESC   = 4'd12;
   localparam logic [3:0] S_CHAR_CLOSE = 4'd13;
   localparam logic [3:0] S_STR        = 4'd14;
   localparam logic [3:0] S_STR_ESC    = 4'd15;

   logic [3:0]    scan_ff, scan_in;
   logic [7:0]    held_ff, held_in, bh_ff, bh_in, last_ff, last_in, lit_ff, lit_in;
   logic [WLW-1:0] wl_ff, wl_in;
   logic [7:0]    wbuf_ff [KEYWORD_MAX_CHARS];
   logic [7:0]    wbuf_in [KEYWORD_MAX_CHARS];
   logic [PB-1:0] pos_ff, pos_in, ts_ff, ts_in, mp_ff, mp_in;
   logic [23:0]   lc_ff, lc_in, tl_ff, tl_in;
   logic [63:0]   lead_ff, lead_in, frac_ff, frac_in, exp_ff, exp_in;
   logic [5:0]    fc_ff, fc_in;
   logic          bad_ff, bad_in;

   rec_type       rec_ff [3];
   rec_type       rec_in [3];
   logic [1:0]    cnt_ff, cnt_in, idx_ff, idx_in;
   logic [1:0]    n_rec;

   logic          req_fire, rsp_fire;
   logic [7:0]    b;

   function automatic logic [PB-1:0] sat1(input logic [PB-1:0] v);
      return (v == POS_MAX) ? POS_MAX : v + PB'(1);
   endfunction

   function automatic logic [PB-1:0] sat2(input logic [PB-1:0] v);
      return (v >= POS_MAX - PB'(1)) ? POS_MAX : v + PB'(2);
   endfunction

   function automatic rec_type mk(input logic [6:0] k, input logic [2:0] e,
                                  input logic [PB-1:0] s, input logic [PB-1:0] en,
                                  input logic [23:0] ln, input logic [63:0] iv,
                                  input logic [63:0] fv, input logic [5:0] fd,
                                  input logic [63:0] ev);
      rec_type r;
      r.kind = k;
      r.err = e;
      r.start_pos = 24'(s);
      r.end_pos = 24'(en);
      r.line = ln;
      r.int_val = iv;
      r.frac_val = fv;
      r.frac_cnt = fd;
      r.exp_val = ev;
      return r;
   endfunction

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_chan.ready);
   assign b = req_chan.byte_in;

   always_comb begin
      logic        em, done;
      rec_type     r;
      logic [63:0] wpack;
      logic [3:0]  wn;
      logic [8:0]  ob;
      logic [7:0]  op2;
      scan_in = scan_ff;
      held_in = held_ff;
      bh_in = bh_ff;
      last_in = last_ff;
      lit_in = lit_ff;
      wl_in = wl_ff;
      wbuf_in = wbuf_ff;
      pos_in = pos_ff;
      ts_in = ts_ff;
      mp_in = mp_ff;
      lc_in = lc_ff;
      tl_in = tl_ff;
      lead_in = lead_ff;
      frac_in = frac_ff;
      exp_in = exp_ff;
      fc_in = fc_ff;
      bad_in = bad_ff;
      rec_in = rec_ff;
      n_rec = 2'd0;
      em = 1'b0;
      done = 1'b0;
      r = '0;
      ob = '0;
      op2 = '0;
      wpack = '0;
      for (int i = 0; i < 8; i++) wpack[8*i +: 8] = wbuf_ff[i];
      wn = (wl_ff <= WLW'(8)) ? 4'(wl_ff) : 4'd0;

      if (req_fire && req_chan.end_of_text) begin
         // flush whatever token is open, then the end token
         unique case (scan_ff)
            S_OP: begin
               ob = op_bare(held_ff);
               if (ob[8]) begin
                  rec_in[n_rec] = mk(ob[6:0], E_NONE, ts_ff, sat1(ts_ff), tl_ff, '0, '0, '0,
                                     '0);
                  n_rec++;
               end
            end
            S_SLASH: begin
               rec_in[n_rec] = mk(K_SLASH, E_NONE, ts_ff, sat1(ts_ff), tl_ff, '0, '0, '0, '0);
               n_rec++;
            end
            S_INT, S_FRAC, S_EXP: begin
               rec_in[n_rec] = mk(bad_ff ? K_ERROR : (scan_ff == S_INT ? K_INT : K_FLOAT),
                                  bad_ff ? E_BAD_DIGIT : E_NONE, ts_ff, pos_ff, tl_ff,
                                  lead_ff, frac_ff, fc_ff, exp_ff);
               n_rec++;
            end
            S_NUM_DOT: begin
               rec_in[n_rec] = mk(bad_ff ? K_ERROR : K_FLOAT, bad_ff ? E_BAD_DIGIT : E_NONE,
                                  ts_ff, mp_ff, tl_ff, lead_ff, frac_ff, fc_ff, exp_ff);
               n_rec++;
               rec_in[n_rec] = mk(K_DOT, E_NONE, mp_ff, sat1(mp_ff), tl_ff, '0, '0, '0, '0);
               n_rec++;
            end
            S_IDENT: begin
               rec_in[n_rec] = mk(word_kind(wpack, wn), E_NONE, ts_ff, pos_ff, tl_ff, '0, '0,
                                  '0, '0);
               n_rec++;
            end
            S_DIRECT: begin
               rec_in[n_rec] = mk(is_load(wpack, wn) ? K_LOAD : K_ERROR,
                                  is_load(wpack, wn) ? E_NONE : E_DIRECT, ts_ff, pos_ff, tl_ff,
                                  '0, '0, '0, '0);
               n_rec++;
            end
            S_CHAR_OPEN, S_CHAR_ESC, S_CHAR_CLOSE: begin
               rec_in[n_rec] = mk(K_ERROR, E_OPEN_CHAR, ts_ff, pos_ff, tl_ff, '0, '0, '0, '0);
               n_rec++;
            end
            S_STR, S_STR_ESC: begin
               rec_in[n_rec] = mk(K_ERROR, E_OPEN_STR, ts_ff, pos_ff, tl_ff, '0, '0, '0, '0);
               n_rec++;
            end
            default: ;
         endcase
         rec_in[n_rec] = mk(K_END, E_NONE, pos_ff, pos_ff, 24'd0, '0, '0, '0, '0);
         n_rec++;
         scan_in = S_IDLE;
         held_in = '0;
         bh_in = '0;
         last_in = '0;
         lit_in = '0;
         wl_in = '0;
         for (int i = 0; i < KEYWORD_MAX_CHARS; i++) wbuf_in[i] = '0;
         pos_in = '0;
         ts_in = '0;
         mp_in = '0;
         lc_in = 24'd1;
         tl_in = 24'd1;
         lead_in = '0;
         frac_in = '0;
         exp_in = '0;
         fc_in = '0;
         bad_in = 1'b0;
      end else if (req_fire) begin
         // a byte may be rescanned: number-dot, then operator, then idle at most
         for (int p = 0; p < 3; p++) begin
            if (!done) begin
               em = 1'b0;
               done = 1'b1;
               unique case (scan_in)
                  S_IDLE: begin
                     ts_in = pos_in;
                     tl_in = lc_in;
                     ob = op_bare(b);
                     if (b == CH_LF) begin
                        em = 1'b1;
                        r = mk(K_EOL, E_NONE, ts_in, sat1(pos_in), tl_in, '0, '0, '0, '0);
                        if (lc_in != LINE_TOP) lc_in = lc_in + 24'd1;
                     end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
                        em = 1'b0;
                     end else if (b == CH_QUOTE) begin
                        scan_in = S_CHAR_OPEN;
                     end else if (b == CH_DQUOTE) begin
                        scan_in = S_STR;
                     end else if (b == CH_SLASH) begin
                        bh_in = last_ff;
                        scan_in = S_SLASH;
                     end else if (b == CH_HASH) begin
                        wl_in = '0;
                        scan_in = S_DIRECT;
                     end else if (b >= "0" && b <= "9") begin
                        lead_in = 64'(hex_val(b));
                        frac_in = '0;
                        fc_in = '0;
                        exp_in = '0;
                        bad_in = 1'b0;
                        scan_in = S_INT;
                     end else if (ob[8]) begin
                        if (!ob[7]) begin
                           em = 1'b1;
                           r = mk(ob[6:0], E_NONE, ts_in, sat1(pos_in), tl_in, '0, '0, '0, '0);
                        end else begin
                           held_in = b;
                           scan_in = S_OP;
                        end
                     end else if (is_letter(b)) begin
                        wbuf_in[0] = b;
                        wl_in = WLW'(1);
                        scan_in = S_IDENT;
                     end else begin
                        em = 1'b1;
                        r = mk(K_ERROR, E_BAD_CHAR, ts_in, sat1(pos_in), tl_in, '0, '0, '0, '0);
                     end
                  end
                  S_OP: begin
                     scan_in = S_IDLE;
                     ob = op_bare(held_in);
                     op2 = op_pair(held_in, b);
                     if (!ob[8]) begin
                        done = 1'b0;
                     end else if (op2[7]) begin
                        em = 1'b1;
                        r = mk(op2[6:0], E_NONE, ts_in, sat2(ts_in), tl_in, '0, '0, '0, '0);
                     end else begin
                        em = 1'b1;
                        r = mk(ob[6:0], E_NONE, ts_in, sat1(ts_in), tl_in, '0, '0, '0, '0);
                        done = 1'b0;
                     end
                  end
                  S_SLASH: begin
                     scan_in = S_IDLE;
                     if (b == CH_SLASH) begin
                        scan_in = S_LINE_CMT;
                     end else if (b == CH_STAR) begin
                        // a star just before the slash closes the comment at once
                        if (bh_in == CH_STAR) done = 1'b0;
                        else begin
                           held_in = CH_STAR;
                           scan_in = S_BLOCK_CMT;
                        end
                     end else if (b == CH_EQ) begin
                        em = 1'b1;
                        r = mk(K_SLASH_ASSIGN, E_NONE, ts_in, sat2(ts_in), tl_in, '0, '0, '0,
                               '0);
                     end else begin
                        em = 1'b1;
                        r = mk(K_SLASH, E_NONE, ts_in, sat1(ts_in), tl_in, '0, '0, '0, '0);
                        done = 1'b0;
                     end
                  end
                  S_LINE_CMT: begin
                     if (b == CH_LF) begin
                        scan_in = S_IDLE;
                        done = 1'b0;
                     end
                  end
                  S_BLOCK_CMT: begin
                     if (b == CH_SLASH && held_in == CH_STAR) scan_in = S_IDLE;
                     else begin
                        if (b == CH_LF && lc_in != LINE_TOP) lc_in = lc_in + 24'd1;
                        held_in = b;
                     end
                  end
                  S_INT: begin
                     if (b == CH_DOT) begin
                        mp_in = pos_in;
                        scan_in = S_NUM_DOT;
                     end else if (b == CH_LOW_E || b == CH_UP_E) begin
                        scan_in = S_EXP;
                     end else if (is_hex(b)) begin
                        if (hex_val(b) > 4'd9) bad_in = 1'b1;
                        lead_in = mul10_add(lead_in, hex_val(b));
                     end else begin
                        em = 1'b1;
                        r = mk(bad_in ? K_ERROR : K_INT, bad_in ? E_BAD_DIGIT : E_NONE, ts_in,
                               pos_in, tl_in, lead_in, frac_in, fc_in, exp_in);
                        scan_in = S_IDLE;
                        done = 1'b0;
                     end
                  end
                  S_NUM_DOT: begin
                     done = 1'b0;
                     if (is_hex(b)) scan_in = S_FRAC;
                     else begin
                        // float ends before the dot; the dot is rescanned as an operator
                        em = 1'b1;
                        r = mk(bad_in ? K_ERROR : K_FLOAT, bad_in ? E_BAD_DIGIT : E_NONE,
                               ts_in, mp_in, tl_in, lead_in, frac_in, fc_in, exp_in);
                        ts_in = mp_in;
                        held_in = CH_DOT;
                        scan_in = S_OP;
                     end
                  end
                  S_FRAC: begin
                     if (b == CH_LOW_E || b == CH_UP_E) begin
                        scan_in = S_EXP;
                     end else if (is_hex(b)) begin
                        if (hex_val(b) > 4'd9) bad_in = 1'b1;
                        frac_in = mul10_add(frac_in, hex_val(b));
                        if (fc_in != 6'd63) fc_in = fc_in + 6'd1;
                     end else begin
                        em = 1'b1;
                        r = mk(bad_in ? K_ERROR : K_FLOAT, bad_in ? E_BAD_DIGIT : E_NONE,
                               ts_in, pos_in, tl_in, lead_in, frac_in, fc_in, exp_in);
                        scan_in = S_IDLE;
                        done = 1'b0;
                     end
                  end
                  S_EXP: begin
                     if (is_hex(b)) begin
                        if (hex_val(b) > 4'd9) bad_in = 1'b1;
                        exp_in = mul10_add(exp_in, hex_val(b));
                     end else begin
                        em = 1'b1;
                        r = mk(bad_in ? K_ERROR : K_FLOAT, bad_in ? E_BAD_DIGIT : E_NONE,
                               ts_in, pos_in, tl_in, lead_in, frac_in, fc_in, exp_in);
                        scan_in = S_IDLE;
                        done = 1'b0;
                     end
                  end
                  S_IDENT, S_DIRECT: begin
                     if (is_ident(b)) begin
                        if (wl_in < WLW'(KEYWORD_MAX_CHARS)) begin
                           wbuf_in[wl_in[IW-1:0]] = b;
                           wl_in = wl_in + WLW'(1);
                        end else wl_in = WLW'(KEYWORD_MAX_CHARS + 1);
                     end else begin
                        em = 1'b1;
                        if (scan_in == S_IDENT)
                           r = mk(word_kind(wpack, wn), E_NONE, ts_in, pos_in, tl_in, '0, '0,
                                  '0, '0);
                        else
                           r = mk(is_load(wpack, wn) ? K_LOAD : K_ERROR,
                                  is_load(wpack, wn) ? E_NONE : E_DIRECT, ts_in, pos_in, tl_in,
                                  '0, '0, '0, '0);
                        scan_in = S_IDLE;
                        done = 1'b0;
                     end
                  end
                  S_CHAR_OPEN: begin
                     if (b == CH_BSLASH) scan_in = S_CHAR_ESC;
                     else begin
                        lit_in = b;
                        scan_in = S_CHAR_CLOSE;
                     end
                  end
                  S_CHAR_ESC: begin
                     if (b == CH_LOW_X || b == CH_LOW_B) begin
                        em = 1'b1;
                        r = mk(K_ERROR, E_NUM_ESC, ts_in, sat1(pos_in), tl_in, '0, '0, '0, '0);
                        scan_in = S_IDLE;
                     end else begin
                        lit_in = escape_value(b);
                        scan_in = S_CHAR_CLOSE;
                     end
                  end
                  S_CHAR_CLOSE: begin
                     scan_in = S_IDLE;
                     em = 1'b1;
                     if (b == CH_QUOTE)
                        r = mk(K_CHAR, E_NONE, ts_in, sat1(pos_in), tl_in, 64'(lit_in), '0, '0,
                               '0);
                     else begin
                        r = mk(K_ERROR, E_OPEN_CHAR, ts_in, pos_in, tl_in, '0, '0, '0, '0);
                        done = 1'b0;
                     end
                  end
                  S_STR: begin
                     if (b == CH_DQUOTE) begin
                        em = 1'b1;
                        r = mk(K_STR, E_NONE, ts_in, sat1(pos_in), tl_in, '0, '0, '0, '0);
                        scan_in = S_IDLE;
                     end else if (b == CH_BSLASH) begin
                        scan_in = S_STR_ESC;
                     end else if (b == CH_LF) begin
                        em = 1'b1;
                        r = mk(K_ERROR, E_OPEN_STR, ts_in, pos_in, tl_in, '0, '0, '0, '0);
                        scan_in = S_IDLE;
                        done = 1'b0;
                     end
                  end
                  S_STR_ESC: begin
                     if (b == CH_LOW_X || b == CH_LOW_B) begin
                        em = 1'b1;
                        r = mk(K_ERROR, E_NUM_ESC, ts_in, sat1(pos_in), tl_in, '0, '0, '0, '0);
                        scan_in = S_IDLE;
                     end else scan_in = S_STR;
                  end
                  default: begin
                     scan_in = S_IDLE;
                     done = 1'b0;
                  end
               endcase
               if (em && n_rec != 2'd3) begin
                  rec_in[n_rec] = r;
                  n_rec++;
               end
            end
         end
         last_in = b;
         pos_in = sat1(pos_in);
      end
   end

   // record buffer: loaded whole per accepted word, drains one record a cycle when ready
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (req_fire) begin
         cnt_in = n_rec;
         idx_in = 2'd0;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= S_IDLE;
         held_ff <= '0;
         bh_ff <= '0;
         last_ff <= '0;
         lit_ff <= '0;
         wl_ff <= '0;
         for (int i = 0; i < KEYWORD_MAX_CHARS; i++) wbuf_ff[i] <= '0;
         pos_ff <= '0;
         ts_ff <= '0;
         mp_ff <= '0;
         lc_ff <= 24'd1;
         tl_ff <= 24'd1;
         lead_ff <= '0;
         frac_ff <= '0;
         exp_ff <= '0;
         fc_ff <= '0;
         bad_ff <= 1'b0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         scan_ff <= scan_in;
         held_ff <= held_in;
         bh_ff <= bh_in;
         last_ff <= last_in;
         lit_ff <= lit_in;
         wl_ff <= wl_in;
         wbuf_ff <= wbuf_in;
         pos_ff <= pos_in;
         ts_ff <= ts_in;
         mp_ff <= mp_in;
         lc_ff <= lc_in;
         tl_ff <= tl_in;
         lead_ff <= lead_in;
         frac_ff <= frac_in;
         exp_ff <= exp_in;
         fc_ff <= fc_in;
         bad_ff <= bad_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rsp_chan.valid = (cnt_ff != 2'd0);
   assign rsp_chan.token_kind = rec_ff[idx_ff].kind;
   assign rsp_chan.error_code = rec_ff[idx_ff].err;
   assign rsp_chan.start_pos = rec_ff[idx_ff].start_pos;
   assign rsp_chan.end_pos = rec_ff[idx_ff].end_pos;
   assign rsp_chan.line_no = rec_ff[idx_ff].line;
   assign rsp_chan.int_value = rec_ff[idx_ff].int_val;
   assign rsp_chan.frac_value = rec_ff[idx_ff].frac_val;
   assign rsp_chan.frac_digits = rec_ff[idx_ff].frac_cnt;
   assign rsp_chan.exp_value = rec_ff[idx_ff].exp_val;
   assign rsp_chan.last_token = (cnt_ff == 2'd1);

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.end_of_text |=> scan_ff == S_IDLE && pos_ff == '0 && lc_ff == 24'd1)
      else $error("scanner not back at reset state after end word");

   a_end_gives_rec: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.end_of_text |=> cnt_ff != 2'd0 && idx_ff == 2'd0)
      else $error("end word produced no record");

   a_buf_bounds: assert property (@(posedge clock) disable iff (reset)
      3'(idx_ff) + 3'(cnt_ff) <= 3'd3)
      else $error("record buffer index overrun");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      lc_ff != 24'd0 && tl_ff != 24'd0)
      else $error("line count reached zero");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !req_fire |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("record buffer count slipped");

endmodule
